[design/arcp_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arcp_pkg
// Shared types and constants for the adaptive replacement policy directory.
// ----------------------------------------------------------------------------
package arcp_pkg;

  localparam int unsigned MaxEntriesDef = 64;
  localparam int unsigned KeyBitsDef    = 32;
  localparam int unsigned CapW          = 7;
  localparam logic [CapW-1:0] CapResetVal = 7'd64;
  localparam int unsigned KindW         = 3;
  localparam int unsigned TargetW       = 7;
  localparam int unsigned OutTdataW     = 16;

  // list membership code of one directory slot
  typedef enum logic [2:0] {
    L_EMPTY   = 3'd0,
    L_RECENT  = 3'd1,
    L_FREQ    = 3'd2,
    L_RGHOST  = 3'd3,
    L_FGHOST  = 3'd4
  } list_e;

  // datapath operations
  typedef enum logic [3:0] {
    OP_CLEAR,
    OP_LOOKUP,
    OP_FIND,
    OP_DIV,
    OP_MV_HIT,
    OP_MV_EVICT,
    OP_MV_TRIM,
    OP_MV_INST
  } op_e;

  typedef struct packed {
    logic start;
    op_e  op;
  } cmd_t;

  typedef struct packed {
    logic  done;
    list_e kind;
    logic  cap_full;
    logic  ev_ok;
    logic  trim_need;
    logic  inst_ok;
  } sts_t;

  typedef enum logic [4:0] {
    ST_CLR,
    ST_CLR_W,
    ST_IDLE,
    ST_LOOK_W,
    ST_DISP,
    ST_HIT_W,
    ST_DIV_W,
    ST_EVF,
    ST_EVF_W,
    ST_EVM,
    ST_EVM_W,
    ST_TRF,
    ST_TRF_W,
    ST_TRM,
    ST_TRM_W,
    ST_INF,
    ST_INF_W,
    ST_INM,
    ST_INM_W,
    ST_OUT
  } state_e;

endpackage

[design/arcp_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arcp_ctrl
// Sequencer: orders lookup, target update, eviction, ghost trim and install.
// ----------------------------------------------------------------------------
module arcp_ctrl
  import arcp_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  logic out_free_i,
  output logic emit_o,
  output cmd_t cmd_o,
  input  sts_t sts_i
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '{start: 1'b0, op: OP_FIND};
    in_ready_o = 1'b0;
    emit_o     = 1'b0;
    case (state_q)
      ST_CLR: begin
        cmd_o   = '{start: 1'b1, op: OP_CLEAR};
        state_d = ST_CLR_W;
      end
      ST_CLR_W: if (sts_i.done) state_d = ST_IDLE;
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o   = '{start: 1'b1, op: OP_LOOKUP};
          state_d = ST_LOOK_W;
        end
      end
      ST_LOOK_W: if (sts_i.done) state_d = ST_DISP;
      ST_DISP: begin
        if (sts_i.kind == L_RECENT || sts_i.kind == L_FREQ) begin
          cmd_o   = '{start: 1'b1, op: OP_MV_HIT};
          state_d = ST_HIT_W;
        end else if (sts_i.kind == L_RGHOST || sts_i.kind == L_FGHOST) begin
          cmd_o   = '{start: 1'b1, op: OP_DIV};
          state_d = ST_DIV_W;
        end else if (sts_i.cap_full) begin
          state_d = ST_EVF;
        end else begin
          state_d = ST_INF;
        end
      end
      ST_HIT_W: if (sts_i.done) state_d = ST_OUT;
      ST_DIV_W: if (sts_i.done) state_d = ST_EVF;
      ST_EVF: begin
        cmd_o   = '{start: 1'b1, op: OP_FIND};
        state_d = ST_EVF_W;
      end
      ST_EVF_W: if (sts_i.done) state_d = ST_EVM;
      ST_EVM: begin
        if (sts_i.ev_ok) begin
          cmd_o   = '{start: 1'b1, op: OP_MV_EVICT};
          state_d = ST_EVM_W;
        end else begin
          state_d = ST_TRF;
        end
      end
      ST_EVM_W: if (sts_i.done) state_d = ST_TRF;
      ST_TRF: begin
        cmd_o   = '{start: 1'b1, op: OP_FIND};
        state_d = ST_TRF_W;
      end
      ST_TRF_W: if (sts_i.done) state_d = ST_TRM;
      ST_TRM: begin
        if (sts_i.trim_need) begin
          cmd_o   = '{start: 1'b1, op: OP_MV_TRIM};
          state_d = ST_TRM_W;
        end else begin
          state_d = ST_INF;
        end
      end
      ST_TRM_W: if (sts_i.done) state_d = ST_TRF;
      ST_INF: begin
        cmd_o   = '{start: 1'b1, op: OP_FIND};
        state_d = ST_INF_W;
      end
      ST_INF_W: if (sts_i.done) state_d = ST_INM;
      ST_INM: begin
        if (sts_i.inst_ok) begin
          cmd_o   = '{start: 1'b1, op: OP_MV_INST};
          state_d = ST_INM_W;
        end else begin
          state_d = ST_OUT;
        end
      end
      ST_INM_W: if (sts_i.done) state_d = ST_OUT;
      ST_OUT: begin
        if (out_free_i) begin
          emit_o  = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_CLR;
    endcase
  end

endmodule

[design/arcp_dpath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arcp_dpath
// Slot memory with sweep engine, list counters, target and ratio divider.
// ----------------------------------------------------------------------------
module arcp_dpath
  import arcp_pkg::*;
#(
  parameter int unsigned MAX_ENTRIES = MaxEntriesDef,
  parameter int unsigned KEY_BITS    = KeyBitsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cmd_t                cmd_i,
  output sts_t                sts_o,
  input  logic [KEY_BITS-1:0] key_i,
  input  logic [CapW-1:0]     cap_i,
  output logic                res_hit_o,
  output list_e               res_kind_o,
  output logic [TargetW-1:0]  res_target_o
);

  localparam int unsigned Slots = 2 * MAX_ENTRIES;
  localparam int unsigned SW    = $clog2(Slots);
  localparam int unsigned CW    = $clog2(Slots + 1);
  localparam int unsigned DCW   = $clog2(CW + 1);

  typedef struct packed {
    logic [KEY_BITS-1:0] key;
    list_e               lst;
    logic [CW-1:0]       rank;
  } row_t;

  row_t row_mem_q [Slots];
  row_t rdata_q, wr_row;
  logic wr_en, rd_en;

  logic [KEY_BITS-1:0] key_q;
  list_e               kind_q;
  logic [CW-1:0]       tgt_q;
  logic [CW-1:0]       cnt_q [4];
  logic [CW-1:0]       cnt_d [4];
  logic [CW-1:0]       cap_eff;

  // sweep engine
  logic          sw_act_q;
  logic [SW:0]   sw_cnt_q;
  logic          pv_q;
  logic [SW-1:0] paddr_q;
  op_e           sw_op_q;
  logic          sw_done, sw_start, is_find, is_move;

  // find results
  logic          m_found_q, m_found_d;
  logic [SW-1:0] m_slot_q, m_slot_d;
  list_e         m_list_q, m_list_d;
  logic [CW-1:0] m_rank_q, m_rank_d;
  logic          f_found_q, f_found_d;
  logic [SW-1:0] f_slot_q, f_slot_d;
  logic          o_found_q [4];
  logic          o_found_d [4];
  logic [SW-1:0] o_slot_q [4];
  logic [SW-1:0] o_slot_d [4];

  // move parameters
  logic [SW-1:0] mv_slot_q, mv_slot_c;
  list_e         mv_l1_q, mv_l1_c, mv_l2_q, mv_l2_c;
  logic [CW-1:0] mv_r_q, mv_r_c;
  logic          mv_wk_q, mv_wk_c;

  // divider
  logic           div_act_q;
  logic [DCW-1:0] div_cnt_q;
  logic [CW-1:0]  quo_q, rem_q, den_q;
  logic [CW:0]    div_tmp;
  logic           div_ge, div_done;
  logic [CW-1:0]  div_num, div_den, step_d;
  logic [CW:0]    tgt_sum;
  logic [CW-1:0]  tgt_new;

  logic          ev_rec, ev_frq, ev_ok, trim_need, tr_rg;
  logic [1:0]    tr_idx;

  always_comb begin
    if (cap_i == '0) begin
      cap_eff = CW'(1);
    end else if (32'(cap_i) > 32'(MAX_ENTRIES)) begin
      cap_eff = CW'(MAX_ENTRIES);
    end else begin
      cap_eff = CW'(cap_i);
    end
  end

  // eviction and trim choices; counter index is list code minus one
  assign ev_rec = (cnt_q[0] != '0) && ((cnt_q[0] > tgt_q) || (cnt_q[1] == '0));
  assign ev_frq = !ev_rec && (cnt_q[1] != '0);
  assign ev_ok  = (ev_rec && o_found_q[0]) || (ev_frq && o_found_q[1]);
  assign tr_rg  = cnt_q[2] > cnt_q[3];
  assign tr_idx = tr_rg ? 2'd2 : 2'd3;
  assign trim_need = (({1'b0, cnt_q[2]} + {1'b0, cnt_q[3]}) > {1'b0, cap_eff})
                     && o_found_q[tr_idx];

  assign is_move = (cmd_i.op == OP_MV_HIT) || (cmd_i.op == OP_MV_EVICT) ||
                   (cmd_i.op == OP_MV_TRIM) || (cmd_i.op == OP_MV_INST);
  assign sw_start = cmd_i.start && (cmd_i.op != OP_DIV);
  assign is_find  = (sw_op_q == OP_FIND) || (sw_op_q == OP_LOOKUP);

  always_comb begin
    mv_slot_c = '0;
    mv_l1_c   = L_EMPTY;
    mv_l2_c   = L_EMPTY;
    mv_r_c    = '0;
    mv_wk_c   = 1'b0;
    case (cmd_i.op)
      OP_MV_HIT: begin
        mv_slot_c = m_slot_q;
        mv_l1_c   = m_list_q;
        mv_r_c    = m_rank_q;
        mv_l2_c   = L_FREQ;
      end
      OP_MV_EVICT: begin
        if (ev_rec) begin
          mv_slot_c = o_slot_q[0];
          mv_l1_c   = L_RECENT;
          mv_r_c    = cnt_q[0] - CW'(1);
          mv_l2_c   = L_RGHOST;
        end else begin
          mv_slot_c = o_slot_q[1];
          mv_l1_c   = L_FREQ;
          mv_r_c    = cnt_q[1] - CW'(1);
          mv_l2_c   = L_FGHOST;
        end
      end
      OP_MV_TRIM: begin
        mv_slot_c = o_slot_q[tr_idx];
        mv_l1_c   = tr_rg ? L_RGHOST : L_FGHOST;
        mv_r_c    = cnt_q[tr_idx] - CW'(1);
      end
      OP_MV_INST: begin
        if (m_found_q) begin
          mv_slot_c = m_slot_q;
          mv_l1_c   = m_list_q;
          mv_r_c    = m_rank_q;
        end else begin
          mv_slot_c = f_slot_q;
        end
        mv_l2_c = (kind_q == L_EMPTY) ? L_RECENT : L_FREQ;
        mv_wk_c = 1'b1;
      end
      default: mv_slot_c = '0;
    endcase
  end

  // counters move with the slot at the start of a move sweep
  always_comb begin
    for (int j = 0; j < 4; j++) begin
      cnt_d[j] = cnt_q[j];
      if (cmd_i.start && is_move) begin
        if (mv_l1_c != L_EMPTY && 2'(mv_l1_c - L_RECENT) == 2'(j)) begin
          cnt_d[j] = cnt_d[j] - CW'(1);
        end
        if (mv_l2_c != L_EMPTY && 2'(mv_l2_c - L_RECENT) == 2'(j)) begin
          cnt_d[j] = cnt_d[j] + CW'(1);
        end
      end
    end
  end

  // sweep control
  assign sw_done = sw_act_q && (sw_cnt_q == (SW + 1)'(Slots));
  assign rd_en   = sw_act_q && (sw_cnt_q < (SW + 1)'(Slots));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sw_act_q <= 1'b0;
      sw_cnt_q <= '0;
      pv_q     <= 1'b0;
      sw_op_q  <= OP_CLEAR;
    end else begin
      if (sw_start) begin
        sw_act_q <= 1'b1;
        sw_cnt_q <= '0;
        sw_op_q  <= cmd_i.op;
        pv_q     <= 1'b0;
      end else if (sw_act_q) begin
        if (rd_en) begin
          sw_cnt_q <= sw_cnt_q + (SW + 1)'(1);
          pv_q     <= 1'b1;
        end else begin
          sw_act_q <= 1'b0;
          pv_q     <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      paddr_q <= sw_cnt_q[SW-1:0];
    end
  end

  // per-row processing
  always_comb begin
    logic dec, inc;
    wr_row = rdata_q;
    wr_en  = 1'b0;
    dec    = 1'b0;
    inc    = 1'b0;
    if (pv_q) begin
      case (sw_op_q)
        OP_CLEAR: begin
          wr_en      = 1'b1;
          wr_row.lst = L_EMPTY;
        end
        OP_MV_HIT, OP_MV_EVICT, OP_MV_TRIM, OP_MV_INST: begin
          wr_en = 1'b1;
          if (paddr_q == mv_slot_q) begin
            wr_row.lst  = mv_l2_q;
            wr_row.rank = '0;
            if (mv_wk_q) wr_row.key = key_q;
          end else begin
            dec = (mv_l1_q != L_EMPTY) && (rdata_q.lst == mv_l1_q) && (rdata_q.rank > mv_r_q);
            inc = (mv_l2_q != L_EMPTY) && (rdata_q.lst == mv_l2_q);
            wr_row.rank = rdata_q.rank - CW'(dec) + CW'(inc);
          end
        end
        default: wr_en = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) row_mem_q[paddr_q] <= wr_row;
    if (rd_en) rdata_q <= row_mem_q[sw_cnt_q[SW-1:0]];
  end

  // find: key match, first free slot, oldest of each list
  always_comb begin
    m_found_d = m_found_q;
    m_slot_d  = m_slot_q;
    m_list_d  = m_list_q;
    m_rank_d  = m_rank_q;
    f_found_d = f_found_q;
    f_slot_d  = f_slot_q;
    for (int j = 0; j < 4; j++) begin
      o_found_d[j] = o_found_q[j];
      o_slot_d[j]  = o_slot_q[j];
    end
    if (sw_start) begin
      m_found_d = 1'b0;
      f_found_d = 1'b0;
      for (int j = 0; j < 4; j++) o_found_d[j] = 1'b0;
    end else if (pv_q && is_find) begin
      if (rdata_q.lst != L_EMPTY && rdata_q.key == key_q && !m_found_q) begin
        m_found_d = 1'b1;
        m_slot_d  = paddr_q;
        m_list_d  = rdata_q.lst;
        m_rank_d  = rdata_q.rank;
      end
      if (rdata_q.lst == L_EMPTY && !f_found_q) begin
        f_found_d = 1'b1;
        f_slot_d  = paddr_q;
      end
      for (int j = 0; j < 4; j++) begin
        if (rdata_q.lst != L_EMPTY && 2'(rdata_q.lst - L_RECENT) == 2'(j) &&
            rdata_q.rank == cnt_q[j] - CW'(1) && !o_found_q[j]) begin
          o_found_d[j] = 1'b1;
          o_slot_d[j]  = paddr_q;
        end
      end
    end
  end

  // divider operands: ratio of the other ghost list to the hit one
  assign div_num = (kind_q == L_RGHOST) ? cnt_q[3] : cnt_q[2];
  assign div_den = (kind_q == L_RGHOST) ? cnt_q[2] : cnt_q[3];
  assign div_tmp = {rem_q, quo_q[CW-1]};
  assign div_ge  = div_tmp >= {1'b0, den_q};
  assign div_done = div_act_q && (div_cnt_q == '0);
  assign step_d  = (quo_q == '0) ? CW'(1) : quo_q;
  assign tgt_sum = {1'b0, tgt_q} + {1'b0, step_d};

  always_comb begin
    if (kind_q == L_RGHOST) begin
      tgt_new = (tgt_sum > {1'b0, cap_eff}) ? cap_eff : tgt_sum[CW-1:0];
    end else begin
      tgt_new = (tgt_q > step_d) ? tgt_q - step_d : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_act_q <= 1'b0;
      div_cnt_q <= '0;
      tgt_q     <= '0;
      kind_q    <= L_EMPTY;
      m_found_q <= 1'b0;
      f_found_q <= 1'b0;
      for (int j = 0; j < 4; j++) begin
        cnt_q[j]     <= '0;
        o_found_q[j] <= 1'b0;
      end
    end else begin
      for (int j = 0; j < 4; j++) begin
        cnt_q[j]     <= cnt_d[j];
        o_found_q[j] <= o_found_d[j];
      end
      m_found_q <= m_found_d;
      f_found_q <= f_found_d;
      if (sw_done && sw_op_q == OP_LOOKUP) begin
        kind_q <= m_found_d ? m_list_d : L_EMPTY;
      end
      if (cmd_i.start && cmd_i.op == OP_DIV) begin
        div_act_q <= 1'b1;
        div_cnt_q <= DCW'(CW);
      end else if (div_done) begin
        div_act_q <= 1'b0;
        tgt_q     <= tgt_new;
      end else if (div_act_q) begin
        div_cnt_q <= div_cnt_q - DCW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    m_slot_q <= m_slot_d;
    m_list_q <= m_list_d;
    m_rank_q <= m_rank_d;
    f_slot_q <= f_slot_d;
    for (int j = 0; j < 4; j++) o_slot_q[j] <= o_slot_d[j];
    if (cmd_i.start && cmd_i.op == OP_LOOKUP) key_q <= key_i;
    if (cmd_i.start && is_move) begin
      mv_slot_q <= mv_slot_c;
      mv_l1_q   <= mv_l1_c;
      mv_l2_q   <= mv_l2_c;
      mv_r_q    <= mv_r_c;
      mv_wk_q   <= mv_wk_c;
    end
    if (cmd_i.start && cmd_i.op == OP_DIV) begin
      quo_q <= div_num;
      rem_q <= '0;
      den_q <= (div_den == '0) ? CW'(1) : div_den;
    end else if (div_act_q && !div_done) begin
      rem_q <= div_ge ? CW'(div_tmp - {1'b0, den_q}) : div_tmp[CW-1:0];
      quo_q <= {quo_q[CW-2:0], div_ge};
    end
  end

  assign sts_o.done      = sw_done || div_done;
  assign sts_o.kind      = kind_q;
  assign sts_o.cap_full  = ({1'b0, cnt_q[0]} + {1'b0, cnt_q[1]}) >= {1'b0, cap_eff};
  assign sts_o.ev_ok     = ev_ok;
  assign sts_o.trim_need = trim_need;
  assign sts_o.inst_ok   = m_found_q || f_found_q;

  assign res_hit_o    = (kind_q == L_RECENT) || (kind_q == L_FREQ);
  assign res_kind_o   = kind_q;
  assign res_target_o = TargetW'(tgt_q);

endmodule

[design/adaptive_replacement_cache_policy.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adaptive_replacement_cache_policy
// Adaptive replacement directory: resident and ghost lists with adaptive target.
// ----------------------------------------------------------------------------
// Usage
//  - s_axis: one key per transfer. m_axis: one result per key
//    (hit, hit kind, recent-list target after the access).
//  - cfg_wen_i/cfg_wdata_i: capacity register, user writes only while idle
//    (unenforced). Zero acts as one, values above MAX_ENTRIES act as MAX_ENTRIES.
//  - Slot state lives in a single-port-write memory of 2*MAX_ENTRIES rows,
//    scanned one row per cycle.
//  - Scans per key: resident hit 2; plain miss 3 to 6 plus one scan
//    pair per trimmed ghost; ghost hit as a full miss, after a divider
//    run that updates the target.
//  - After reset a clearing pass empties every slot; s_axis_tready stays
//    low until it ends. Capacity resets to 64.
//  - The result sits in an output register; a new key is taken while it
//    waits. If the receiver stalls, the next result holds the block until
//    the register frees.
// ----------------------------------------------------------------------------
module adaptive_replacement_cache_policy
  import arcp_pkg::*;
#(
  parameter int unsigned MAX_ENTRIES = MaxEntriesDef,
  parameter int unsigned KEY_BITS    = KeyBitsDef
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // tdata: key
  input  logic [((KEY_BITS+7)/8)*8-1:0]     s_axis_tdata,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // tdata: hit [0], hit_kind [3:1], target [10:4], zero pad
  output logic [OutTdataW-1:0]              m_axis_tdata,
  input  logic                              cfg_wen_i,
  input  logic [CapW-1:0]                   cfg_wdata_i
);

  logic [CapW-1:0]     cap_q;
  cmd_t                cmd;
  sts_t                sts;
  logic                emit, out_free;
  logic                res_hit;
  list_e               res_kind;
  logic [TargetW-1:0]  res_target;
  logic                m_valid_q;
  logic [OutTdataW-1:0] m_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CapResetVal;
    end else if (cfg_wen_i) begin
      cap_q <= cfg_wdata_i;
    end
  end

  // output register frees when its transfer completes
  assign out_free = !m_valid_q || m_axis_tready;

  arcp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .out_free_i (out_free),
    .emit_o     (emit),
    .cmd_o      (cmd),
    .sts_i      (sts)
  );

  arcp_dpath #(
    .MAX_ENTRIES (MAX_ENTRIES),
    .KEY_BITS    (KEY_BITS)
  ) u_dpath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .key_i        (s_axis_tdata[KEY_BITS-1:0]),
    .cap_i        (cap_q),
    .res_hit_o    (res_hit),
    .res_kind_o   (res_kind),
    .res_target_o (res_target)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (emit) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      m_data_q <= {5'b0, res_target, res_kind, res_hit};
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

endmodule

[design/arcp_chk.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arcp_chk
// Port-level checks for the adaptive replacement directory.
// ----------------------------------------------------------------------------
module arcp_chk
  import arcp_pkg::*;
(
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 s_axis_tvalid,
  input logic                 s_axis_tready,
  input logic                 m_axis_tvalid,
  input logic                 m_axis_tready,
  input logic [OutTdataW-1:0] m_axis_tdata
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result dropped or changed while stalled");

  // hit flag agrees with the kind
  a_hit_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[0] ==
      (m_axis_tdata[3:1] == 3'(L_RECENT) || m_axis_tdata[3:1] == 3'(L_FREQ)))
    else $error("hit flag inconsistent with kind");

  // kind stays within the five codes
  a_kind_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[3:1] <= 3'(L_FGHOST))
    else $error("kind out of range");

  // one key in flight: busy after a transfer
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("second key taken while busy");

endmodule

bind adaptive_replacement_cache_policy arcp_chk u_arcp_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
